>>> design/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, codes and constants of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

	// number of keys and default press counter width
	localparam int KEYS          = 2;
	localparam int COUNT_WIDTH_D = 16;

	// configuration register width and index width
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME  = 1'b1;

	// reset values of the thresholds
	localparam logic [CFG_W-1:0] SHORT_TIME_RST = 16'd3;
	localparam logic [CFG_W-1:0] HOLD_TIME_RST  = 16'd100;

	// operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// per-key classification
	typedef enum logic [2:0] {
		ST_NONE  = 3'd0,
		ST_SHORT = 3'd1,
		ST_LONG  = 3'd2,
		ST_HOLD  = 3'd3,
		ST_BUSY  = 3'd4
	} key_class_t;

	// input item
	typedef struct packed {
		logic            operation;
		logic [KEYS-1:0] pressed;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [3*KEYS-1:0] key_states;
		logic [KEYS-1:0]   pair_mask;
		logic [2:0]        pair_state;
	} out_item_t;

	// control shared by all lanes for one transfer
	typedef struct packed {
		logic fire;
		logic clear;
		logic any_pressed;
	} lane_ctrl_t;

endpackage

>>> design/kpc_lane.sv
// ----------------------------------------------------------------------------
// kpc_lane
// One key: saturating press counter and classification of its count.
// ----------------------------------------------------------------------------
module kpc_lane
	import kpc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_D
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lane_ctrl_t       ctrl,
	input  logic             key_pressed,
	input  logic [CFG_W-1:0] short_time,
	input  logic [CFG_W-1:0] hold_time,
	output key_class_t       key_class
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic [CMP_W-1:0]       count_x;
	logic                   over_hold;
	logic                   over_short;

	// saturating increment of a pressed key
	always_comb begin
		if (key_pressed && (count_q != {COUNT_WIDTH{1'b1}})) begin
			count_inc = count_q + COUNT_WIDTH'(1);
		end else begin
			count_inc = count_q;
		end
	end

	// threshold compares on a common width
	assign count_x    = CMP_W'(count_inc);
	assign over_hold  = count_x > CMP_W'(hold_time);
	assign over_short = count_x > CMP_W'(short_time);

	// classification of this key
	always_comb begin
		if (ctrl.clear) begin
			key_class = ST_NONE;
		end else if (!ctrl.any_pressed) begin
			if (over_hold) begin
				key_class = ST_LONG;
			end else if (over_short) begin
				key_class = ST_SHORT;
			end else begin
				key_class = ST_NONE;
			end
		end else if (over_hold) begin
			key_class = ST_HOLD;
		end else begin
			key_class = ST_BUSY;
		end
	end

	// counter update, cleared once all keys are released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.fire && !ctrl.clear) begin
			if (!ctrl.any_pressed) begin
				count_q <= '0;
			end else begin
				count_q <= count_inc;
			end
		end
	end

endmodule

>>> design/kpc_pair_merge.sv
// ----------------------------------------------------------------------------
// kpc_pair_merge
// Merges the lane states: sticky record of the last matching key pair.
// ----------------------------------------------------------------------------
module kpc_pair_merge
	import kpc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctrl_t              ctrl,
	input  key_class_t [KEYS-1:0]   lane_state,
	output logic [KEYS-1:0]         pair_mask,
	output logic [2:0]              pair_state
);

	logic [KEYS-1:0] pair_bits_q;
	logic [2:0]      pair_status_q;
	logic            found;
	logic [KEYS-1:0] found_mask;
	logic [2:0]      found_state;

	// scan all pairs in order, the last match wins
	always_comb begin
		found       = 1'b0;
		found_mask  = '0;
		found_state = ST_NONE;
		for (int i = 0; i < KEYS - 1; i++) begin
			for (int j = i + 1; j < KEYS; j++) begin
				if ((lane_state[i] == lane_state[j]) && (lane_state[i] != ST_NONE)) begin
					found         = 1'b1;
					found_mask    = '0;
					found_mask[i] = 1'b1;
					found_mask[j] = 1'b1;
					found_state   = lane_state[i];
				end
			end
		end
	end

	// value reported with this transfer
	always_comb begin
		if (ctrl.clear) begin
			pair_mask  = '0;
			pair_state = pair_status_q;
		end else if (found) begin
			pair_mask  = found_mask;
			pair_state = found_state;
		end else begin
			pair_mask  = pair_bits_q;
			pair_state = pair_status_q;
		end
	end

	// sticky pair record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_bits_q   <= '0;
			pair_status_q <= ST_NONE;
		end else if (ctrl.fire) begin
			pair_bits_q   <= pair_mask;
			pair_status_q <= pair_state;
		end
	end

endmodule

>>> design/kpc_out_buf.sv
// ----------------------------------------------------------------------------
// kpc_out_buf
// Result register with a skid stage, so input and output stall independently.
// ----------------------------------------------------------------------------
module kpc_out_buf
	import kpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      can_push,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      head_v_q;
	logic      skid_v_q;
	out_item_t head_q;
	out_item_t skid_q;
	logic      pop;

	assign pop       = head_v_q && out_ready;
	assign can_push  = !skid_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !head_v_q) begin
			head_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop || !head_v_q) begin
			if (skid_v_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

>>> design/key_press_classifier_core.sv
// ----------------------------------------------------------------------------
// key_press_classifier_core
// Short/long press classifier over a group of keys with a pair detector.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   input    | in_valid, in_ready, in_data      | in
//   result   | out_valid, out_ready, out_data   | out
//   config   | cfg_we, cfg_index, cfg_wdata     | in
//
// One item per cycle while in_ready is high; lane classes and the pair merge
// are combinational; each result is registered in the output or skid stage.
// Reset clears the counters, the pair record and the thresholds to 3 / 100.
// A two-entry output buffer keeps input transfers going while a result waits;
// in_ready falls only when both entries are full.
// ----------------------------------------------------------------------------
module key_press_classifier_core
	import kpc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [CFG_W-1:0]      short_time_q;
	logic [CFG_W-1:0]      hold_time_q;
	lane_ctrl_t            ctrl;
	key_class_t [KEYS-1:0] lane_state;
	logic [KEYS-1:0]       pair_mask_new;
	logic [2:0]            pair_state_new;
	out_item_t             result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_time_q <= SHORT_TIME_RST;
			hold_time_q  <= HOLD_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_TIME: short_time_q <= cfg_wdata;
				REG_HOLD_TIME:  hold_time_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// transfer control for the lanes
	assign ctrl.fire        = in_valid && in_ready;
	assign ctrl.clear       = (in_data.operation == OP_CLEAR);
	assign ctrl.any_pressed = |in_data.pressed;

	// one lane per key
	for (genvar k = 0; k < KEYS; k++) begin : g_lane
		kpc_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key_pressed(in_data.pressed[k]),
			.short_time (short_time_q),
			.hold_time  (hold_time_q),
			.key_class  (lane_state[k])
		);
		assign result.key_states[3*k +: 3] = lane_state[k];
	end

	// pair merge
	kpc_pair_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.lane_state(lane_state),
		.pair_mask (pair_mask_new),
		.pair_state(pair_state_new)
	);

	assign result.pair_mask  = pair_mask_new;
	assign result.pair_state = pair_state_new;

	// output register and skid stage
	kpc_out_buf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ctrl.fire),
		.push_data(result),
		.can_push (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// a clear transfer reports an empty pair mask
	a_clear_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.fire && ctrl.clear) |-> (pair_mask_new == '0))
		else $error("pair mask not cleared on clear transfer");

	// a reported pair mask names no key or exactly two
	a_pair_bits: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fire |-> (($countones(pair_mask_new) == 0) || ($countones(pair_mask_new) == 2)))
		else $error("pair mask does not hold a key pair");

	// input stalls only while a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");
`endif

endmodule

>>> dv/tb_key_press_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_key_press_classifier_core
// Self-checking bench for the key press classifier core.
//
// A scoreboard object tracks its own copy of the press counters, key states,
// pair record and thresholds. It predicts one result for every input
// transfer and checks each result transfer against the oldest prediction.
// Stimulus starts with short directed press/release/clear sequences, then
// runs random press sequences under several threshold settings. Both
// channels get random stalls, and the result side also gets one long
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_key_press_classifier_core;
	import kpc_pkg::*;

	localparam int LIMIT_CYCLES    = 800000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int DRAIN_CYCLES    = 4;

	// prediction of the classifier and store of pending results
	class press_scoreboard;
		logic [COUNT_WIDTH_D-1:0] counts [KEYS];
		key_class_t               status [KEYS];
		logic [KEYS-1:0]          pair_bits;
		key_class_t               pair_status;
		logic [CFG_W-1:0]         short_time;
		logic [CFG_W-1:0]         hold_time;
		out_item_t                pending_q [$];
		int                       errors;

		function new();
			for (int k = 0; k < KEYS; k++) begin
				counts[k] = '0;
				status[k] = ST_NONE;
			end
			pair_bits   = '0;
			pair_status = ST_NONE;
			short_time  = SHORT_TIME_RST;
			hold_time   = HOLD_TIME_RST;
			errors      = 0;
		endfunction

		function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx == REG_SHORT_TIME)
				short_time = value;
			else if (idx == REG_HOLD_TIME)
				hold_time = value;
		endfunction

		// advance the key state for one accepted item and queue its result
		function void note_input(in_item_t it);
			out_item_t res;
			if (it.operation == OP_CLEAR) begin
				for (int k = 0; k < KEYS; k++)
					status[k] = ST_NONE;
				pair_bits = '0;
			end else begin
				// saturating counters for pressed keys
				for (int k = 0; k < KEYS; k++)
					if (it.pressed[k] && counts[k] != {COUNT_WIDTH_D{1'b1}})
						counts[k] = counts[k] + 1'b1;
				// classify on full release, otherwise hold or busy
				for (int k = 0; k < KEYS; k++) begin
					if (it.pressed == '0) begin
						if (counts[k] > hold_time)
							status[k] = ST_LONG;
						else if (counts[k] > short_time)
							status[k] = ST_SHORT;
						else
							status[k] = ST_NONE;
						counts[k] = '0;
					end else if (counts[k] > hold_time) begin
						status[k] = ST_HOLD;
					end else begin
						status[k] = ST_BUSY;
					end
				end
				// sticky pair record, last matching pair wins
				for (int i = 0; i + 1 < KEYS; i++)
					for (int j = i + 1; j < KEYS; j++)
						if (status[i] == status[j] && status[i] != ST_NONE) begin
							pair_bits   = '0;
							pair_bits[i] = 1'b1;
							pair_bits[j] = 1'b1;
							pair_status = status[i];
						end
			end
			res = '0;
			for (int k = 0; k < KEYS; k++)
				res.key_states[3*k +: 3] = status[k];
			res.pair_mask  = pair_bits;
			res.pair_state = pair_status;
			pending_q.push_back(res);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result %h", got));
			end else begin
				want = pending_q.pop_front();
				if (got.key_states !== want.key_states)
					report($sformatf("key_states got %h want %h",
						got.key_states, want.key_states));
				if (got.pair_mask !== want.pair_mask)
					report($sformatf("pair_mask got %h want %h",
						got.pair_mask, want.pair_mask));
				if (got.pair_state !== want.pair_state)
					report($sformatf("pair_state got %h want %h",
						got.pair_state, want.pair_state));
			end
		endtask
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SHORT_TIME;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	press_scoreboard board;
	bit              tx_idle_on   = 1'b0;
	bit              rx_idle_on   = 1'b0;
	bit              hold_off_req = 1'b0;
	int              cycles       = 0;

	key_press_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// result side ready: random stalls plus one long hold-off on request
	initial begin : result_sink
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// result transfer check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	function automatic in_item_t make_item(logic op, logic [KEYS-1:0] keys);
		in_item_t it;
		it.operation = op;
		it.pressed   = keys;
		return it;
	endfunction

	// offer one item and wait for its transfer; valid stays up afterwards
	task automatic send(in_item_t it);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(it);
	endtask

	task automatic tick(logic [KEYS-1:0] keys);
		send(make_item(OP_TICK, keys));
	endtask

	// stop offering and wait until every pending result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_thresholds(logic [CFG_W-1:0] short_v, logic [CFG_W-1:0] hold_v);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SHORT_TIME;
		cfg_wdata <= short_v;
		@(posedge clk);
		board.set_threshold(REG_SHORT_TIME, short_v);
		cfg_index <= REG_HOLD_TIME;
		cfg_wdata <= hold_v;
		@(posedge clk);
		board.set_threshold(REG_HOLD_TIME, hold_v);
		cfg_we    <= 1'b0;
	endtask

	// random press sequences, mostly well formed, some clears and noise
	task automatic random_presses(int n_items, int max_len);
		int              sent;
		int              len;
		int              pick;
		logic [KEYS-1:0] mask;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send(make_item(OP_CLEAR, KEYS'($urandom_range(0, 3))));
				sent++;
			end else if (pick == 1) begin
				tick(KEYS'($urandom_range(0, 3)));
				sent++;
			end else begin
				mask = KEYS'($urandom_range(1, 3));
				len  = $urandom_range(1, max_len);
				for (int n = 0; n < len; n++) begin
					if ($urandom_range(0, 7) == 0)
						tick(KEYS'($urandom_range(1, 3)));
					else
						tick(mask);
					sent++;
				end
				tick('0);
				sent++;
			end
		end
	endtask

	initial begin : main
		board = new();

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, short press, no match, pair busy/short, clear
		send(make_item(OP_CLEAR, 2'b11));
		tick(2'b00);
		repeat (5) tick(2'b01);
		tick(2'b00);
		repeat (2) tick(2'b10);
		tick(2'b00);
		repeat (4) tick(2'b11);
		tick(2'b00);
		send(make_item(OP_CLEAR, 2'b10));
		tick(2'b00);

		// directed: low thresholds for hold and long
		write_thresholds(16'd1, 16'd3);
		repeat (5) tick(2'b11);
		tick(2'b00);
		repeat (2) tick(2'b01);
		tick(2'b10);
		tick(2'b00);
		send(make_item(OP_CLEAR, 2'b01));

		// random with stalls on both sides, long hold-off at the start
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		write_thresholds(16'd2, 16'd6);
		hold_off_req = 1'b1;
		random_presses(150, 10);
		drain();
		random_presses(150, 10);

		// zero thresholds
		write_thresholds(16'd0, 16'd0);
		random_presses(150, 4);

		// stretch with no stalls
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_thresholds(16'd5, 16'd12);
		random_presses(250, 16);

		// maximum thresholds and mixed extremes
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		write_thresholds(16'hFFFF, 16'hFFFF);
		random_presses(100, 8);
		write_thresholds(16'd0, 16'hFFFF);
		random_presses(100, 8);
		write_thresholds(16'hFFFF, 16'd0);
		random_presses(100, 8);

		// random with stalls again
		write_thresholds(16'd3, 16'd9);
		random_presses(300, 14);

		// last part without stalls
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_thresholds(16'd4, 16'd20);
		random_presses(250, 28);

		// wind down
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending_q.size() != 0)
			board.report($sformatf("%0d results never arrived", board.pending_q.size()));
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
